// ===== rtl/pce_pkg.sv =====
package pce_pkg;

    localparam int COEF_W = 32;
    localparam int TERM_W = 33;
    localparam int ACC_W  = 48;
    localparam int FRAC_W = 16;
    localparam int DEG_W  = 5;

    localparam logic signed [ACC_W-1:0]    ACC_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0]    ACC_MIN  = 48'sh8000_0000_0000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN = 32'sh8000_0000;
    localparam logic [2*COEF_W-1:0]        RND_HALF = 64'h0000_0000_0000_8000;

    typedef enum logic [2:0] {
        CMD_ASSIGN   = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_EVAL     = 3'd3,
        CMD_INTEGRAL = 3'd4
    } pce_cmd_t;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [4:0]               exponent;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [COEF_W-1:0] point_a;
        logic signed [COEF_W-1:0] point_b;
    } pce_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [DEG_W-1:0]        degree;
        logic                    all_zero;
        logic                    flag;
    } pce_result_t;

    typedef struct packed {
        logic init;
        logic step;
    } pce_hctl_t;

    typedef enum logic [2:0] {
        HP_IDLE,
        HP_MUL,
        HP_RND,
        HP_ADD,
        HP_ABS
    } pce_hphase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_SCAN,
        ST_RD,
        ST_LOAD,
        ST_DIV,
        ST_STEP,
        ST_RESP
    } pce_state_t;

endpackage

// ===== rtl/polynomial_coefficient_engine.sv =====
// Polynomial table of signed Q16.16 coefficients, kept in a single-port-write,
// registered-read RAM with one nonzero bit per entry (cleared at reset and by
// the clear command, so no clearing pass is needed). An item is taken when
// start is high and busy is low; its single result beat appears on result
// with done high for one cycle, and the receiver cannot stall it. Assign writes
// as it is taken and add reads, then writes, before the response; a zero write to
// the top coefficient also forces a downward search, one index at a time, for the
// new degree. Evaluation walks the table by Horner's rule through one shared
// multiply-accumulate unit that takes each term through multiply, round, add
// and magnitude steps after a memory fetch in the read and load states. The
// integral walks the table twice and divides each coefficient by its new
// exponent in a radix-16 divider.
module polynomial_coefficient_engine #(
    parameter int MAX_EXPONENT = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pce_pkg::pce_item_t   item,
    output logic                 done,
    output pce_pkg::pce_result_t result
);
    import pce_pkg::*;

    localparam int DEPTH = MAX_EXPONENT + 1;
    localparam int IW    = $clog2(DEPTH);

    pce_state_t state_reg, state_next;

    logic [2:0]               cmd_reg;
    logic [IW-1:0]            ex_reg;
    logic signed [COEF_W-1:0] cv_reg;
    logic signed [COEF_W-1:0] pa_reg;
    logic                     pass_reg, pass_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic signed [ACC_W-1:0]  hi_reg, hi_next;
    logic                     flag_reg, flag_next;
    logic [IW-1:0]            deg_reg, deg_next;
    logic [DEPTH-1:0]         nz_reg, nz_next;
    logic                     rd_nz_reg;
    pce_result_t              res_reg, res_next;
    logic                     strobe_reg, strobe_next;

    logic                     accept;
    logic                     ex_ok;
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic signed [COEF_W-1:0] wr_data;
    logic [IW-1:0]            raddr;
    logic signed [COEF_W-1:0] rdata;
    logic signed [COEF_W-1:0] rd_val;
    logic signed [COEF_W:0]   add_sum;
    logic signed [ACC_W:0]    diff;
    logic                     diff_sat;

    pce_hctl_t                hctl;
    logic signed [COEF_W-1:0] hx;
    logic signed [TERM_W-1:0] hterm;
    logic                     h_done;
    logic signed [ACC_W-1:0]  h_acc;
    logic                     h_sat;

    logic                     div_start;
    logic                     div_done;
    logic signed [TERM_W-1:0] div_quot;

    pce_ram #(
        .WIDTH(COEF_W),
        .DEPTH(DEPTH)
    ) u_coef_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(raddr),
        .rdata(rdata)
    );

    pce_horner u_horner (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (hctl),
        .x    (hx),
        .term (hterm),
        .done (h_done),
        .acc  (h_acc),
        .sat  (h_sat)
    );

    pce_div #(
        .IW(IW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .coef (rd_val),
        .idx  (idx_reg),
        .done (div_done),
        .quot (div_quot)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign ex_ok  = 32'(item.exponent) <= 32'(MAX_EXPONENT);

    // An entry never written, or cleared, reads as zero through its nonzero bit.
    assign rd_val  = rd_nz_reg ? rdata : '0;
    assign add_sum = (COEF_W+1)'(rd_val) + (COEF_W+1)'(cv_reg);

    assign diff     = (ACC_W+1)'(hi_reg) - (ACC_W+1)'(h_acc);
    assign diff_sat = (diff > (ACC_W+1)'(ACC_MAX)) || (diff < (ACC_W+1)'(ACC_MIN));

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        flag_next   = flag_reg;
        deg_next    = deg_reg;
        nz_next     = nz_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = ex_reg;
        wr_data     = cv_reg;
        raddr       = idx_reg;
        hctl        = '0;
        hx          = item.point_a;
        hterm       = '0;
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    flag_next = (item.cmd == CMD_INTEGRAL) &&
                                (deg_reg == IW'(MAX_EXPONENT));
                    pass_next = 1'b0;
                    idx_next  = IW'(MAX_EXPONENT);
                    unique case (item.cmd)
                        CMD_ASSIGN:
                        begin
                            wr_en      = ex_ok;
                            wr_addr    = IW'(item.exponent);
                            wr_data    = item.coef_value;
                            state_next = ST_RESP;
                        end
                        CMD_ADD:
                        begin
                            raddr      = IW'(item.exponent);
                            state_next = ex_ok ? ST_ADD_WR : ST_RESP;
                        end
                        CMD_CLEAR:
                        begin
                            nz_next    = '0;
                            deg_next   = '0;
                            state_next = ST_RESP;
                        end
                        CMD_EVAL:
                        begin
                            hctl.init  = 1'b1;
                            hx         = item.point_a;
                            state_next = ST_RD;
                        end
                        CMD_INTEGRAL:
                        begin
                            hctl.init  = 1'b1;
                            hx         = item.point_b;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ex_reg;
                if (add_sum[COEF_W] != add_sum[COEF_W-1])
                begin
                    wr_data   = add_sum[COEF_W] ? COEF_MIN : COEF_MAX;
                    flag_next = 1'b1;
                end
                else
                begin
                    wr_data = add_sum[COEF_W-1:0];
                end
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (nz_reg[idx_reg] || (idx_reg == '0))
                begin
                    deg_next   = idx_reg;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_RD:
            begin
                // The integral's term i comes from coefficient i-1.
                raddr      = (cmd_reg == CMD_INTEGRAL) ? (idx_reg - 1'b1) : idx_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cmd_reg == CMD_INTEGRAL)
                begin
                    if (idx_reg == '0)
                    begin
                        hctl.step  = 1'b1;
                        hterm      = '0;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    hctl.step  = 1'b1;
                    hterm      = TERM_W'(rd_val);
                    state_next = ST_STEP;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    hctl.step  = 1'b1;
                    hterm      = div_quot;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (h_done)
                begin
                    if (idx_reg != '0)
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_RD;
                    end
                    else if ((cmd_reg == CMD_INTEGRAL) && !pass_reg)
                    begin
                        // Upper bound done; walk again at the lower bound.
                        hi_next    = h_acc;
                        flag_next  = flag_reg | h_sat;
                        pass_next  = 1'b1;
                        idx_next   = IW'(MAX_EXPONENT);
                        hctl.init  = 1'b1;
                        hx         = pa_reg;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP:
            begin
                res_next.degree   = DEG_W'(deg_reg);
                res_next.all_zero = ~|nz_reg;
                res_next.value    = '0;
                res_next.flag     = flag_reg;
                if (cmd_reg == CMD_EVAL)
                begin
                    res_next.value = h_acc;
                    res_next.flag  = flag_reg | h_sat;
                end
                else if (cmd_reg == CMD_INTEGRAL)
                begin
                    res_next.value = diff_sat ? (diff[ACC_W] ? ACC_MIN : ACC_MAX)
                                              : diff[ACC_W-1:0];
                    res_next.flag  = flag_reg | h_sat | diff_sat;
                end
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Degree upkeep for any table write. Zeroing the top coefficient
        // starts a downward search for the next nonzero entry.
        if (wr_en)
        begin
            nz_next[wr_addr] = (wr_data != '0);
            if (wr_data != '0)
            begin
                if (wr_addr > deg_reg)
                begin
                    deg_next = wr_addr;
                end
            end
            else if ((wr_addr == deg_reg) && (deg_reg != '0))
            begin
                idx_next   = deg_reg - 1'b1;
                state_next = ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass_reg   <= 1'b0;
            idx_reg    <= '0;
            flag_reg   <= 1'b0;
            deg_reg    <= '0;
            nz_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            idx_reg    <= idx_next;
            flag_reg   <= flag_next;
            deg_reg    <= deg_next;
            nz_reg     <= nz_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item.cmd;
            ex_reg  <= IW'(item.exponent);
            cv_reg  <= item.coef_value;
            pa_reg  <= item.point_a;
        end
        hi_reg    <= hi_next;
        res_reg   <= res_next;
        rd_nz_reg <= nz_reg[raddr];
    end

    assign done   = strobe_reg;
    assign result = res_reg;

endmodule

// ===== rtl/pce_ram.sv =====
module pce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pce_div.sv =====
module pce_div #(
    parameter int IW = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pce_pkg::COEF_W-1:0] coef,
    input  logic [IW-1:0]                     idx,
    output logic                              done,
    output logic signed [pce_pkg::TERM_W-1:0] quot
);
    import pce_pkg::*;

    localparam int NUM_W = COEF_W + 1;
    localparam int RB    = 4;
    localparam int STEPS = (NUM_W + RB - 1) / RB;
    localparam int PAD_W = STEPS * RB;
    localparam int DW    = IW + 1;
    localparam int RW    = IW + 2;
    localparam int CW    = $clog2(STEPS);

    logic [PAD_W-1:0] num_reg;
    logic [PAD_W-1:0] q_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic             neg_reg;

    logic [COEF_W-1:0] mag;
    logic [NUM_W-1:0]  numer;
    logic [PAD_W-1:0]  num_v;
    logic [PAD_W-1:0]  q_v;
    logic [DW-1:0]     rem_v;
    logic [TERM_W-1:0] q_mag;

    // The rounded quotient round(|c| / i) is floor((2|c| + i) / 2i).
    assign mag   = coef[COEF_W-1] ? (~$unsigned(coef) + 1'b1) : $unsigned(coef);
    assign numer = {mag, 1'b0} + NUM_W'(idx);

    // Four restoring steps per cycle on a remainder only a few bits wide.
    always_comb
    begin
        logic [RW-1:0] trial;
        num_v = num_reg;
        q_v   = q_reg;
        rem_v = rem_reg;
        for (int k = 0; k < RB; k++)
        begin
            trial = {rem_v, num_v[PAD_W-1]};
            num_v = {num_v[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_v = DW'(trial - {1'b0, den_reg});
                q_v   = {q_v[PAD_W-2:0], 1'b1};
            end
            else
            begin
                rem_v = DW'(trial);
                q_v   = {q_v[PAD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == CW'(STEPS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= PAD_W'(numer);
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= {idx, 1'b0};
            neg_reg <= coef[COEF_W-1];
        end
        else if (run_reg)
        begin
            num_reg <= num_v;
            q_reg   <= q_v;
            rem_reg <= rem_v;
        end
    end

    assign q_mag = q_reg[TERM_W-1:0];
    assign quot  = neg_reg ? $signed(~q_mag + 1'b1) : $signed(q_mag);
    assign done  = done_reg;

endmodule

// ===== rtl/pce_horner.sv =====
module pce_horner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pce_pkg::pce_hctl_t                ctl,
    input  logic signed [pce_pkg::COEF_W-1:0] x,
    input  logic signed [pce_pkg::TERM_W-1:0] term,
    output logic                              done,
    output logic signed [pce_pkg::ACC_W-1:0]  acc,
    output logic                              sat
);
    import pce_pkg::*;

    localparam int MAG_W = ACC_W + 1;

    pce_hphase_t phase_reg, phase_next;
    logic        sat_reg, sat_next;

    logic [COEF_W-1:0]        mx_reg;
    logic                     x_neg_reg;
    logic [ACC_W-1:0]         ma_reg;
    logic                     acc_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [ACC_W-1:0]         ph_reg;
    logic [2*COEF_W-1:0]      pl_reg;

    logic [ACC_W-1:0]        ph_w;
    logic [2*COEF_W-1:0]     pl_w;
    logic                    prod_neg;
    logic [MAG_W-1:0]        limit;
    logic [ACC_W-1:0]        rnd;
    logic [MAG_W-1:0]        mag_raw;
    logic [MAG_W-1:0]        mag;
    logic                    mul_sat;
    logic signed [ACC_W-1:0] prod_w;
    logic signed [MAG_W-1:0] sum;
    logic                    add_sat;
    logic signed [ACC_W-1:0] sum_clip;
    logic [COEF_W-1:0]       x_mag;
    logic [ACC_W-1:0]        acc_mag;

    // The 48 x 32 product is split into two partial products of at most 32 x 32.
    assign ph_w = ma_reg[ACC_W-1:COEF_W] * mx_reg;
    assign pl_w = ma_reg[COEF_W-1:0] * mx_reg;

    // Magnitude rounding then sign gives round to nearest, ties away from zero.
    assign prod_neg = acc_neg_reg ^ x_neg_reg;
    assign limit    = {1'b0, prod_neg, {(ACC_W-1){~prod_neg}}};
    assign rnd      = ACC_W'((pl_reg + RND_HALF) >> FRAC_W);
    assign mag_raw  = MAG_W'({ph_reg[COEF_W-1:0], {FRAC_W{1'b0}}}) + MAG_W'(rnd);
    assign mul_sat  = (|ph_reg[ACC_W-1:COEF_W]) || (mag_raw > limit);
    assign mag      = mul_sat ? limit : mag_raw;
    assign prod_w   = ACC_W'(prod_neg ? (~mag + 1'b1) : mag);

    assign sum      = MAG_W'(prod_reg) + MAG_W'(term_reg);
    assign add_sat  = (sum > MAG_W'(ACC_MAX)) || (sum < MAG_W'(ACC_MIN));
    assign sum_clip = add_sat ? (sum[MAG_W-1] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

    assign x_mag   = x[COEF_W-1] ? (~$unsigned(x) + 1'b1) : $unsigned(x);
    assign acc_mag = acc_reg[ACC_W-1] ? (~$unsigned(acc_reg) + 1'b1) : $unsigned(acc_reg);

    always_comb
    begin
        phase_next = phase_reg;
        sat_next   = sat_reg;
        if (ctl.init)
        begin
            phase_next = HP_IDLE;
            sat_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                HP_IDLE:
                begin
                    if (ctl.step)
                    begin
                        phase_next = HP_MUL;
                    end
                end
                HP_MUL:
                begin
                    phase_next = HP_RND;
                end
                HP_RND:
                begin
                    phase_next = HP_ADD;
                    sat_next   = sat_reg | mul_sat;
                end
                HP_ADD:
                begin
                    phase_next = HP_ABS;
                    sat_next   = sat_reg | add_sat;
                end
                HP_ABS:
                begin
                    phase_next = HP_IDLE;
                end
                default:
                begin
                    phase_next = HP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HP_IDLE;
            sat_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            mx_reg      <= x_mag;
            x_neg_reg   <= x[COEF_W-1];
            acc_reg     <= '0;
            ma_reg      <= '0;
            acc_neg_reg <= 1'b0;
        end
        else
        begin
            if (ctl.step)
            begin
                term_reg <= term;
            end
            unique case (phase_reg)
                HP_MUL:
                begin
                    ph_reg <= ph_w;
                    pl_reg <= pl_w;
                end
                HP_RND:
                begin
                    prod_reg <= prod_w;
                end
                HP_ADD:
                begin
                    acc_reg <= sum_clip;
                end
                HP_ABS:
                begin
                    ma_reg      <= acc_mag;
                    acc_neg_reg <= acc_reg[ACC_W-1];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done = (phase_reg == HP_ABS);
    assign acc  = acc_reg;
    assign sat  = sat_reg;

endmodule

// ===== rtl/pce_checker.sv =====
module pce_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input pce_pkg::pce_item_t   item,
    input logic                 done,
    input pce_pkg::pce_result_t result
);
    import pce_pkg::*;

    // Every accepted item raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // Busy drops exactly when the one result beat of the item is shown.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats for one item");

    a_empty_degree: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.all_zero |-> result.degree == '0)
        else $error("empty table reported a nonzero degree");

endmodule

bind polynomial_coefficient_engine pce_checker u_pce_checker (.*);
